>>> sv/frc_pkg.sv
package frc_pkg;

	localparam int LINE_BYTES  = 512;
	localparam int STORE_DEPTH = LINE_BYTES + 1;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [2:0] ST_PENDING    = 3'd0;
	localparam logic [2:0] ST_COMPLETE   = 3'd1;
	localparam logic [2:0] ST_REJECTED   = 3'd2;
	localparam logic [2:0] ST_INCOMPLETE = 3'd3;
	localparam logic [2:0] ST_READ       = 3'd4;

	localparam logic [7:0] CFG_START_FIRST  = 8'd0;
	localparam logic [7:0] CFG_START_SECOND = 8'd1;
	localparam logic [7:0] CFG_CONT_FIRST   = 8'd2;
	localparam logic [7:0] CFG_CONT_SECOND  = 8'd3;

	localparam logic [1:0] MODE_IGNORE = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_CONT   = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
		logic       line_end;
		logic [8:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] payload_len;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic       bad;
		logic       pad;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
		if (c >= 8'h41 && c <= 8'h5A) s.val = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A) s.val = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39) s.val = 6'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B) s.val = 6'd62;
		else if (c == 8'h2F) s.val = 6'd63;
		else if (c == 8'h3D) s.pad = 1'b1;
		else s.bad = 1'b1;
		return s;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> sv/base64_crc16_frame_receiver_unit.sv
// Steps: a read item passes S_RD; a character item passes S_EMIT when it
// yields bytes, then S_EOL; a line end with more than two stored bytes adds
// S_CHK0 to S_CHK2 for the length check, then the S_CRC walk when that check
// passes, one frame store byte per cycle through the single read port.
// Throughput: one item at a time; the next is taken while a result waits in the output register.
// Reset (arst_n low): control state cleared, pairs return to 6/9 and 4/20;
// frame store contents stay undefined until written.
module base64_crc16_frame_receiver_unit
	import frc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	ram_req_t  ram_req;
	logic [7:0] ram_rdata;
	logic      res_valid, res_ready;
	out_item_t res_item;
	logic      out_valid_q;
	out_item_t out_item_q;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	frc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	frc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item (res_item),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_item_q <= res_item;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while another is in work");

	a_len_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_COMPLETE |-> out_item.payload_len == 9'd0)
		else $error("payload length on a non-complete result");

	a_data_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_READ |-> out_item.read_data == 8'd0)
		else $error("read data on a non-read result");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ram_req.we)
		else $error("store written while idle");

endmodule

>>> sv/frc_ram.sv
module frc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> sv/frc_ctrl.sv
module frc_ctrl
	import frc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item,
	input  logic      cfg_valid,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	output ram_req_t  ram_req,
	input  logic [7:0] ram_rdata
);

	localparam int SUM_W = ((CNT_W > 9) ? CNT_W : 9) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_EMIT, S_EOL, S_RD, S_CHK0, S_CHK1, S_CHK2, S_CRC
	} state_t;

	state_t state_q;
	logic [7:0] sf_q, ss_q, cf_q, cs_q;
	logic [CNT_W-1:0] committed_q, tent_q, cnt_q, ptr_q;
	logic [7:0] prefix_q;
	logic [23:0] acc_q, buf_q;
	logic [2:0] fill_q;
	logic err_q, lend_q, rd_ok_q, fin_q;
	logic [1:0] mode_q, ecnt_q;
	logic [7:0] hi_q;
	logic [15:0] crc_q;
	out_item_t res_q;

	sextet_t sx;
	logic [SUM_W-1:0] rsum;
	logic [23:0] acc_n, buf_n;
	logic [2:0] fill_n;
	logic err_n;
	logic [1:0] ecnt_n;
	logic [15:0] word, crc_n;
	logic accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !fin_q;
	assign res_valid = fin_q;
	assign res_item = res_q;
	assign sx = sextet_of(in_item.char_byte);
	assign rsum = SUM_W'(in_item.read_index) + SUM_W'(2);
	assign word = {hi_q, ram_rdata};
	assign crc_n = crc_byte(crc_q, ram_rdata);

	always_comb begin
		acc_n = acc_q;
		fill_n = fill_q;
		err_n = err_q;
		buf_n = 24'h0;
		ecnt_n = 2'd0;
		if (sx.bad) begin
			err_n = 1'b1;
		end else begin
			unique case (fill_q)
				3'd0, 3'd1, 3'd2: begin
					if (sx.pad) begin
						if (fill_q == 3'd2) fill_n = 3'd6;
						else err_n = 1'b1;
					end else begin
						acc_n = {acc_q[17:0], sx.val};
						fill_n = fill_q + 3'd1;
					end
				end
				3'd3: begin
					if (sx.pad) begin
						buf_n = {acc_q[17:10], acc_q[9:2], 8'h00};
						ecnt_n = 2'd2;
						fill_n = 3'd7;
					end else begin
						buf_n = {acc_q[17:0], sx.val};
						ecnt_n = 2'd3;
						fill_n = 3'd0;
						acc_n = 24'h0;
					end
				end
				3'd6: begin
					if (!sx.pad) begin
						err_n = 1'b1;
					end else begin
						buf_n = {acc_q[11:4], 16'h0};
						ecnt_n = 2'd1;
						fill_n = 3'd7;
					end
				end
				default: err_n = 1'b1;
			endcase
		end
	end

	always_comb begin
		ram_req.we = (state_q == S_EMIT) && (tent_q < CNT_W'(STORE_DEPTH));
		ram_req.waddr = tent_q[ADDR_W-1:0];
		ram_req.wdata = buf_q[23:16];
		ram_req.raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (rsum < SUM_W'(committed_q)) ram_req.raddr = rsum[ADDR_W-1:0];
			end
			S_CHK1: ram_req.raddr = ADDR_W'(1);
			S_CHK2: ram_req.raddr = ADDR_W'(2);
			S_CRC: ram_req.raddr = ptr_q[ADDR_W-1:0];
			default: ram_req.raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sf_q <= 8'd6;
			ss_q <= 8'd9;
			cf_q <= 8'd4;
			cs_q <= 8'd20;
			committed_q <= '0;
			tent_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			prefix_q <= '0;
			acc_q <= '0;
			fill_q <= '0;
			err_q <= 1'b0;
			mode_q <= MODE_IGNORE;
			ecnt_q <= '0;
			fin_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_START_FIRST: sf_q <= cfg_data;
					CFG_START_SECOND: ss_q <= cfg_data;
					CFG_CONT_FIRST: cf_q <= cfg_data;
					CFG_CONT_SECOND: cs_q <= cfg_data;
					default: ;
				endcase
			end
			if (fin_q && res_ready) fin_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						if (in_item.kind) begin
							rd_ok_q <= rsum < SUM_W'(committed_q);
							state_q <= S_RD;
						end else begin
							lend_q <= in_item.line_end;
							cnt_q <= cnt_q + CNT_W'(1);
							if (cnt_q < CNT_W'(2)) begin
								state_q <= S_EOL;
								prefix_q <= in_item.char_byte;
								if (cnt_q == CNT_W'(1)) begin
									if (prefix_q == sf_q && in_item.char_byte == ss_q) begin
										mode_q <= MODE_START;
										committed_q <= '0;
										tent_q <= '0;
									end else if (prefix_q == cf_q &&
										in_item.char_byte == cs_q) begin
										mode_q <= MODE_CONT;
										tent_q <= committed_q;
									end else begin
										mode_q <= MODE_IGNORE;
									end
								end
							end else if (mode_q != MODE_IGNORE && !err_q) begin
								acc_q <= acc_n;
								fill_q <= fill_n;
								err_q <= err_n;
								buf_q <= buf_n;
								ecnt_q <= ecnt_n;
								state_q <= (ecnt_n != 2'd0) ? S_EMIT : S_EOL;
							end else begin
								state_q <= S_EOL;
							end
						end
					end
				end
				S_EMIT: begin
					if (tent_q >= CNT_W'(STORE_DEPTH)) begin
						err_q <= 1'b1;
						state_q <= S_EOL;
					end else begin
						tent_q <= tent_q + CNT_W'(1);
						buf_q <= {buf_q[15:0], 8'h00};
						ecnt_q <= ecnt_q - 2'd1;
						if (ecnt_q == 2'd1) state_q <= S_EOL;
					end
				end
				S_EOL: begin
					if (lend_q || cnt_q >= CNT_W'(STORE_DEPTH)) begin
						prefix_q <= '0;
						cnt_q <= '0;
						acc_q <= '0;
						fill_q <= '0;
						err_q <= 1'b0;
						mode_q <= MODE_IGNORE;
					end
					if (!lend_q || mode_q == MODE_IGNORE) begin
						res_q.status <= ST_PENDING;
						fin_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (err_q || (fill_q != 3'd0 && fill_q != 3'd7)) begin
						res_q.status <= ST_REJECTED;
						fin_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						committed_q <= tent_q;
						res_q.status <= ST_INCOMPLETE;
						if (tent_q > CNT_W'(2)) begin
							state_q <= S_CHK0;
						end else begin
							fin_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_RD: begin
					res_q.status <= ST_READ;
					res_q.read_data <= rd_ok_q ? ram_rdata : 8'h00;
					fin_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CHK0: state_q <= S_CHK1;
				S_CHK1: begin
					hi_q <= ram_rdata;
					state_q <= S_CHK2;
				end
				S_CHK2: begin
					if (word == 16'(tent_q) - 16'd2 && word > 16'd2) begin
						crc_q <= '0;
						ptr_q <= CNT_W'(3);
						state_q <= S_CRC;
					end else begin
						fin_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CRC: begin
					crc_q <= crc_n;
					ptr_q <= ptr_q + CNT_W'(1);
					if (ptr_q == tent_q) begin
						if (crc_n == 16'h0) begin
							res_q.status <= ST_COMPLETE;
							res_q.payload_len <= 9'(tent_q - CNT_W'(4));
							committed_q <= tent_q - CNT_W'(2);
						end
						fin_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> test/tb_base64_crc16_frame_receiver_unit.sv
`timescale 1ns / 1ps

module tb_base64_crc16_frame_receiver_unit;
	import frc_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		in_item_t it;
		bit       drain;
	} pend_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	base64_crc16_frame_receiver_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// frame decoder state
	logic [7:0]  fstore [STORE_DEPTH];
	int          committed, tentative, char_cnt, quad_fill;
	logic [15:0] prefix;
	logic [23:0] quad_acc;
	bit          line_err;
	logic [1:0]  line_mode;
	logic [7:0]  pair_cfg [4] = '{8'd6, 8'd9, 8'd4, 8'd20};

	pend_t       pending [$];
	out_item_t   results_q [$];
	logic [7:0]  fb [$];
	logic [7:0]  line_q [$];
	bit          failed = 1'b0;
	int          got = 0;

	function automatic logic [15:0] crc_upd(logic [15:0] crc, logic [7:0] b);
		crc = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
		return crc;
	endfunction

	function automatic int sextet(logic [7:0] c);
		if (c >= "A" && c <= "Z") return c - "A";
		if (c >= "a" && c <= "z") return c - "a" + 26;
		if (c >= "0" && c <= "9") return c - "0" + 52;
		if (c == "+") return 62;
		if (c == "/") return 63;
		if (c == "=") return -2;
		return -1;
	endfunction

	function automatic logic [7:0] b64c(logic [5:0] v);
		if (v < 26) return 8'("A" + v);
		if (v < 52) return 8'("a" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		return (v == 62) ? 8'h2B : 8'h2F;
	endfunction

	function automatic void store_byte(logic [7:0] b);
		if (tentative >= STORE_DEPTH) begin
			line_err = 1'b1;
			return;
		end
		fstore[tentative] = b;
		tentative++;
	endfunction

	function automatic void decode_char(logic [7:0] c);
		int v;
		v = sextet(c);
		if (v == -1) begin
			line_err = 1'b1;
			return;
		end
		if (quad_fill <= 2) begin
			if (v == -2) begin
				if (quad_fill == 2) quad_fill = 6;
				else line_err = 1'b1;
				return;
			end
			quad_acc = {quad_acc[17:0], 6'(v)};
			quad_fill++;
		end else if (quad_fill == 3) begin
			if (v == -2) begin
				store_byte(quad_acc[17:10]);
				if (!line_err) store_byte(quad_acc[9:2]);
				quad_fill = 7;
				return;
			end
			quad_acc = {quad_acc[17:0], 6'(v)};
			store_byte(quad_acc[23:16]);
			if (!line_err) store_byte(quad_acc[15:8]);
			if (!line_err) store_byte(quad_acc[7:0]);
			quad_fill = 0;
			quad_acc = '0;
		end else if (quad_fill == 6) begin
			if (v != -2) begin
				line_err = 1'b1;
				return;
			end
			store_byte(quad_acc[11:4]);
			quad_fill = 7;
		end else begin
			line_err = 1'b1;
		end
	endfunction

	function automatic void clear_line();
		prefix = '0;
		char_cnt = 0;
		quad_acc = '0;
		quad_fill = 0;
		line_err = 1'b0;
		line_mode = MODE_IGNORE;
	endfunction

	function automatic out_item_t frame_step(in_item_t it);
		out_item_t r;
		int n;
		logic [15:0] crc;
		logic [15:0] word;
		r = '0;
		if (it.kind) begin
			r.status = ST_READ;
			if (it.read_index + 2 < committed && it.read_index + 2 < STORE_DEPTH)
				r.read_data = fstore[it.read_index + 2];
			return r;
		end
		if (char_cnt < 2) begin
			prefix = {prefix[7:0], it.char_byte};
			if (char_cnt == 1) begin
				if (prefix[15:8] == pair_cfg[CFG_START_FIRST]
						&& prefix[7:0] == pair_cfg[CFG_START_SECOND]) begin
					line_mode = MODE_START;
					committed = 0;
					tentative = 0;
				end else if (prefix[15:8] == pair_cfg[CFG_CONT_FIRST]
						&& prefix[7:0] == pair_cfg[CFG_CONT_SECOND]) begin
					line_mode = MODE_CONT;
					tentative = committed;
				end else begin
					line_mode = MODE_IGNORE;
				end
			end
		end else if (line_mode != MODE_IGNORE && !line_err) begin
			decode_char(it.char_byte);
		end
		char_cnt++;
		if (it.line_end) begin
			if (char_cnt < 2 || line_mode == MODE_IGNORE) begin
				r.status = ST_PENDING;
			end else if (line_err || (quad_fill != 0 && quad_fill != 7)) begin
				r.status = ST_REJECTED;
			end else begin
				n = tentative;
				committed = n;
				r.status = ST_INCOMPLETE;
				if (n > 2) begin
					word = {fstore[0], fstore[1]};
					crc = '0;
					for (int i = 2; i < n; i++)
						crc = crc_upd(crc, fstore[i]);
					if (word == n - 2 && word > 2 && crc == 0) begin
						r.status = ST_COMPLETE;
						r.payload_len = 9'(n - 4);
						committed = n - 2;
					end
				end
			end
			clear_line();
		end else if (char_cnt >= STORE_DEPTH) begin
			clear_line();
		end
		return r;
	endfunction

	// stimulus builders
	task automatic push_item(in_item_t it, bit drain);
		pend_t p;
		p.it = it;
		p.drain = drain;
		pending.push_back(p);
	endtask

	task automatic push_read(int idx);
		in_item_t it;
		it.kind = 1'b1;
		it.char_byte = 8'($urandom);
		it.line_end = 1'($urandom);
		it.read_index = 9'(idx);
		push_item(it, 1'b0);
	endtask

	task automatic push_line(bit with_end);
		in_item_t it;
		for (int i = 0; i < line_q.size(); i++) begin
			it.kind = 1'b0;
			it.char_byte = line_q[i];
			it.line_end = with_end && (i == line_q.size() - 1);
			it.read_index = 9'($urandom);
			push_item(it, 1'b0);
		end
	endtask

	task automatic bad_char(output logic [7:0] c);
		do c = 8'($urandom); while (sextet(c) != -1);
	endtask

	// encode fb[lo..hi) behind a pair, then optionally damage it
	task automatic b64_line(logic [7:0] a, logic [7:0] b, int lo, int hi, int mangle);
		int r, pos;
		logic [23:0] w;
		logic [7:0] c;
		line_q = {a, b};
		for (int i = lo; i < hi; i += 3) begin
			r = hi - i;
			w = {fb[i], (r > 1) ? fb[i+1] : 8'd0, (r > 2) ? fb[i+2] : 8'd0};
			line_q.push_back(b64c(w[23:18]));
			line_q.push_back(b64c(w[17:12]));
			line_q.push_back((r > 1) ? b64c(w[11:6]) : 8'h3D);
			line_q.push_back((r > 2) ? b64c(w[5:0]) : 8'h3D);
		end
		pos = (line_q.size() > 2) ? $urandom_range(2, line_q.size() - 1) : 2;
		case (mangle)
			1: begin
				bad_char(c);
				if (line_q.size() > 2) line_q[pos] = c;
				else line_q.push_back(c);
			end
			2: if (line_q.size() > 2) line_q.delete(pos);
			else line_q.push_back(b64c(6'($urandom)));
			3: line_q.insert(pos, 8'h3D);
			default: ;
		endcase
		push_line(1'b1);
	endtask

	task automatic build_frame(int plen, bit corrupt);
		logic [15:0] crc;
		fb = {};
		fb.push_back(8'((plen + 2) >> 8));
		fb.push_back(8'(plen + 2));
		crc = '0;
		for (int i = 0; i < plen; i++) begin
			fb.push_back(8'($urandom));
			crc = crc_upd(crc, fb[$]);
		end
		fb.push_back(crc[15:8]);
		fb.push_back(crc[7:0]);
		if (corrupt) fb[$urandom_range(0, fb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
	endtask

	task automatic send_frame(int plen, bit corrupt, int lines);
		int lo, hi;
		build_frame(plen, corrupt);
		lo = 0;
		for (int l = 0; l < lines; l++) begin
			hi = (l == lines - 1) ? fb.size() : $urandom_range(lo, fb.size());
			if (l == 0)
				b64_line(pair_cfg[CFG_START_FIRST], pair_cfg[CFG_START_SECOND], lo, hi, 0);
			else
				b64_line(pair_cfg[CFG_CONT_FIRST], pair_cfg[CFG_CONT_SECOND], lo, hi, 0);
			lo = hi;
		end
	endtask

	task automatic random_traffic(int count);
		int target, sel, plen;
		target = pending.size() + count;
		while (pending.size() < target) begin
			sel = $urandom_range(0, 99);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 20);
			if (sel < 55) begin
				send_frame(plen, $urandom_range(0, 7) == 0, $urandom_range(1, 3));
				repeat ($urandom_range(0, 4)) push_read($urandom_range(0, plen + 3));
				if ($urandom_range(0, 5) == 0) begin
					build_frame($urandom_range(0, 6), 1'b0);
					b64_line(pair_cfg[CFG_CONT_FIRST], pair_cfg[CFG_CONT_SECOND],
						0, fb.size(), 0);
				end
			end else if (sel < 75) begin
				build_frame(plen, 1'b0);
				if ($urandom_range(0, 1))
					b64_line(pair_cfg[CFG_START_FIRST], pair_cfg[CFG_START_SECOND],
						0, fb.size(), $urandom_range(1, 3));
				else
					b64_line(pair_cfg[CFG_CONT_FIRST], pair_cfg[CFG_CONT_SECOND],
						0, fb.size(), $urandom_range(1, 3));
			end else if (sel < 88) begin
				line_q = {};
				repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom));
				if ($urandom_range(0, 1)) line_q[0] = pair_cfg[$urandom_range(0, 1) * 2];
				push_line(1'b1);
			end else begin
				push_read($urandom_range(0, 511));
			end
			if ($urandom_range(0, 40) == 0) pending[$].drain = 1'b1;
		end
	endtask

	task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= CFG_CONT_SECOND) pair_cfg[idx] = val;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending.size() > 0 || results_q.size() > 0 || in_valid);
		repeat (20) @(posedge clk);
	endtask

	// driver
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) results_q.push_back(frame_step(in_item));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() > 0 && !(pending[0].drain && results_q.size() > 0)) begin
					in_item <= pending.pop_front().it;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int  hold_left = 0;
	bit  held = 1'b0;
	int  pat_cnt = 0;
	int  pat_mode = 0;
	always @(posedge clk) begin
		out_item_t exp_r;
		if (out_valid && out_ready) begin
			got++;
			if (results_q.size() == 0) begin
				$display("%0t: unexpected result %p", $realtime, out_item);
				failed = 1'b1;
			end else begin
				exp_r = results_q.pop_front();
				if (out_item.status != exp_r.status || out_item.payload_len != exp_r.payload_len
						|| out_item.read_data != exp_r.read_data) begin
					$display("%0t: mismatch expected %p actual %p", $realtime, exp_r, out_item);
					failed = 1'b1;
				end
			end
		end
		if (got == 250 && !held) begin
			held = 1'b1;
			hold_left = 600;
		end
		pat_cnt++;
		if (pat_cnt % 64 == 0) pat_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else case (pat_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom);
			default: out_ready <= (pat_cnt % 4 == 0);
		endcase
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		ref_init();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		push_read(0);
		push_read(511);
		line_q = {8'd6};
		push_line(1'b1);
		line_q = {8'd0, 8'd255};
		push_line(1'b1);
		send_frame(1, 1'b0, 1);
		push_read(0);
		send_frame(0, 1'b0, 1);
		random_traffic(40);
		// overflow through a continuation line, then an overlong line
		build_frame(514, 1'b0);
		b64_line(pair_cfg[CFG_START_FIRST], pair_cfg[CFG_START_SECOND], 0, 381, 0);
		b64_line(pair_cfg[CFG_CONT_FIRST], pair_cfg[CFG_CONT_SECOND], 381, fb.size(), 0);
		line_q = {};
		repeat (STORE_DEPTH) line_q.push_back(b64c(6'($urandom)));
		line_q[0] = pair_cfg[CFG_START_FIRST];
		line_q[1] = pair_cfg[CFG_START_SECOND];
		push_line(1'b0);
		send_frame(2, 1'b0, 1);
		wait_idle();

		cfg_write(CFG_START_FIRST, "S");
		cfg_write(CFG_START_SECOND, "M");
		cfg_write(CFG_CONT_FIRST, "C");
		cfg_write(CFG_CONT_SECOND, "N");
		cfg_write(8'd9, 8'd0);
		random_traffic(30);
		wait_idle();

		cfg_write(CFG_START_FIRST, 8'd0);
		cfg_write(CFG_START_SECOND, 8'd0);
		cfg_write(CFG_CONT_FIRST, 8'd255);
		cfg_write(CFG_CONT_SECOND, 8'd255);
		random_traffic(30);
		wait_idle();

		cfg_write(CFG_START_FIRST, 8'hAA);
		cfg_write(CFG_START_SECOND, 8'h55);
		cfg_write(CFG_CONT_FIRST, 8'hAA);
		cfg_write(CFG_CONT_SECOND, 8'h55);
		random_traffic(25);
		wait_idle();

		if (!failed) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	function automatic void ref_init();
		committed = 0;
		tentative = 0;
		clear_line();
	endfunction

endmodule
